>>> hdl/visited_state_min_depth_table_assert.svh
// assertion macros shared by the visited state table rtl
`ifndef VISITED_STATE_MIN_DEPTH_TABLE_ASSERT_SVH
`define VISITED_STATE_MIN_DEPTH_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define VSMD_ASSERT_NOW(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("vsmd assertion failed");

// next-cycle implication, disabled while reset is low
`define VSMD_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("vsmd assertion failed");

`endif

>>> hdl/vsmd_pkg.sv
// shared types and constants for the visited state table
package vsmd_pkg;

	// result codes
	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_EQUAL  = 3'd1,
		ST_WORSE  = 3'd2,
		ST_HIT    = 3'd3,
		ST_MISS   = 3'd4,
		ST_FULL   = 3'd5
	} status_t;

	// operation codes
	typedef enum logic {
		OP_TEST_SET = 1'b0,
		OP_LOOKUP   = 1'b1
	} op_t;

	// mixer multipliers
	localparam logic [63:0] HASH_MUL_1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HASH_MUL_2 = 64'h94d049bb133111eb;

	// mixer shift amounts
	localparam int unsigned HASH_SHR_0 = 30;
	localparam int unsigned HASH_SHR_1 = 27;
	localparam int unsigned HASH_SHR_2 = 31;

	localparam int unsigned TURN_W  = 8;
	localparam int unsigned COUNT_W = 13;

endpackage

>>> hdl/vsmd_store.sv
// single-port-write, single-port-read table memory with registered read data
module vsmd_store
	import vsmd_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/vsmd_hash.sv
// iterative key mixer and home slot reduction on one shared 32x32 multiplier
module vsmd_hash
	import vsmd_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [63:0]                 key,
	output logic                        done,
	output logic [$clog2(CAPACITY)-1:0] slot
);

	localparam int unsigned SLOT_W   = $clog2(CAPACITY);
	localparam bit          CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
	// floor(2^64 / CAPACITY) for a capacity that is not a power of two
	localparam logic [63:0] RECIP    = {64{1'b1}} / 64'(CAPACITY);
	localparam logic [31:0] CAP_WORD = 32'(CAPACITY);

	typedef enum logic [3:0] {
		HS_IDLE,
		HS_MUL_LL,
		HS_MUL_LH,
		HS_MUL_HL,
		HS_FIN,
		HS_RED_LL,
		HS_RED_LH,
		HS_RED_HL,
		HS_RED_HH,
		HS_RED_QC,
		HS_RED_FIX,
		HS_DONE
	} hstate_t;

	hstate_t           state_q;
	logic              round_q;
	logic [63:0]       h_q;
	logic [63:0]       acc_q;
	logic [SLOT_W-1:0] rem_q;

	logic [63:0]       mul_c;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod;
	logic [64:0]       red_sum;
	logic [SLOT_W:0]   rem_est;
	logic [SLOT_W:0]   rem_fix;

	// shared multiplier: mixer partial products, then the reciprocal reduction
	always_comb begin
		mul_c = round_q ? HASH_MUL_2 : HASH_MUL_1;
		case (state_q) inside
			HS_MUL_HL, HS_RED_HL, HS_RED_HH: mul_a = h_q[63:32];
			HS_RED_QC:                       mul_a = acc_q[31:0];
			default:                         mul_a = h_q[31:0];
		endcase
		case (state_q) inside
			HS_MUL_LH:            mul_b = mul_c[63:32];
			HS_RED_LL, HS_RED_HL: mul_b = RECIP[31:0];
			HS_RED_LH, HS_RED_HH: mul_b = RECIP[63:32];
			HS_RED_QC:            mul_b = CAP_WORD;
			default:              mul_b = mul_c[31:0];
		endcase
		prod = mul_a * mul_b;
	end

	// quotient estimate is at most one low, so one subtract finishes the remainder
	always_comb begin
		red_sum = {1'b0, acc_q} + {1'b0, prod};
		rem_est = acc_q[SLOT_W:0];
		if (rem_est >= (SLOT_W + 1)'(CAPACITY)) begin
			rem_fix = rem_est - (SLOT_W + 1)'(CAPACITY);
		end else begin
			rem_fix = rem_est;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			round_q <= 1'b0;
			h_q     <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				HS_IDLE: begin
					if (start) begin
						h_q     <= key ^ (key >> HASH_SHR_0);
						round_q <= 1'b0;
						state_q <= HS_MUL_LL;
					end
				end
				HS_MUL_LL: begin
					acc_q   <= prod;
					state_q <= HS_MUL_LH;
				end
				HS_MUL_LH: begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
					state_q      <= HS_MUL_HL;
				end
				HS_MUL_HL: begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
					state_q      <= HS_FIN;
				end
				HS_FIN: begin
					if (!round_q) begin
						h_q     <= acc_q ^ (acc_q >> HASH_SHR_1);
						round_q <= 1'b1;
						state_q <= HS_MUL_LL;
					end else begin
						h_q <= acc_q ^ (acc_q >> HASH_SHR_2);
						if (CAP_POW2) begin
							state_q <= HS_DONE;
						end else begin
							state_q <= HS_RED_LL;
						end
					end
				end
				// high 64 bits of h * RECIP built from four partial products
				HS_RED_LL: begin
					acc_q   <= {32'd0, prod[63:32]};
					state_q <= HS_RED_LH;
				end
				HS_RED_LH: begin
					acc_q   <= red_sum[63:0];
					state_q <= HS_RED_HL;
				end
				HS_RED_HL: begin
					acc_q   <= {31'd0, red_sum[64:32]};
					state_q <= HS_RED_HH;
				end
				HS_RED_HH: begin
					acc_q   <= acc_q + prod;
					state_q <= HS_RED_QC;
				end
				// remainder estimate is below twice the capacity, low word is enough
				HS_RED_QC: begin
					acc_q   <= {32'd0, h_q[31:0] - prod[31:0]};
					state_q <= HS_RED_FIX;
				end
				HS_RED_FIX: begin
					rem_q   <= rem_fix[SLOT_W-1:0];
					state_q <= HS_DONE;
				end
				HS_DONE: begin
					state_q <= HS_IDLE;
				end
				default: begin
					state_q <= HS_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == HS_DONE);
	assign slot = CAP_POW2 ? h_q[SLOT_W-1:0] : rem_q;

endmodule

>>> hdl/visited_state_min_depth_table.sv
// visited state table: each item is hashed to a home slot, then slots are probed in turn
// when CAPACITY is not a power of two the hash unit adds a reciprocal slot reduction
// one item at a time: a new input is taken only once the last result has been loaded
// the table memory has a single read port and is probed one slot at a time
// after reset the valid marks are swept clear, with tready low meanwhile
// arst_n is asynchronous and active low and clears all control state and the entry count
module visited_state_min_depth_table
	import vsmd_pkg::*;
#(
	parameter int unsigned CAPACITY   = 4096,
	parameter int unsigned KEY_BITS   = 64,
	parameter int unsigned MAX_PROBES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transactions
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // key[63:0], turns[71:64]
	input  logic [0:0]  s_axis_tuser,  // op[0]
	// result transactions
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // stored_turns[7:0], entry_count[20:8], zero pad
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

`include "visited_state_min_depth_table_assert.svh"

	// derived sizes
	localparam int unsigned SLOT_W  = $clog2(CAPACITY);
	localparam int unsigned LIMIT   = (MAX_PROBES < CAPACITY) ? MAX_PROBES : CAPACITY;
	localparam int unsigned PRB_W   = $clog2(LIMIT + 1);
	localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
	localparam int unsigned ENTRY_W = KEY_BITS + TURN_W + 1;

	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(CAPACITY - 1);
	localparam logic [PRB_W-1:0]  PROBE_LAST = PRB_W'(LIMIT - 1);
	localparam logic [63:0]       KEY_MASK   = {64{1'b1}} >> (64 - KEY_BITS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TURN_W-1:0]   turns_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [PRB_W-1:0]    probe_q;
	logic [CNT_W-1:0]    occ_q;

	// output register
	logic                m_valid_q;
	status_t             status_q;
	logic [TURN_W-1:0]   held_q;
	logic [COUNT_W-1:0]  count_q;

	// hash unit
	logic                hash_done;
	logic [SLOT_W-1:0]   hash_slot;
	logic [63:0]         key_in;

	// table memory
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [ENTRY_W-1:0]  mem_rdata;

	// probe decision
	logic                ent_valid;
	logic [TURN_W-1:0]   ent_turns;
	logic [KEY_BITS-1:0] ent_key;
	logic                out_free;
	logic                res_done;
	logic                res_write;
	logic                res_inc;
	logic                res_fire;
	status_t             res_status;
	logic [TURN_W-1:0]   res_held;
	logic [CNT_W-1:0]    occ_next;
	logic [31:0]         occ_wide;

	assign key_in = s_axis_tdata[63:0] & KEY_MASK;

	vsmd_hash #(
		.CAPACITY (CAPACITY)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_IDLE && s_axis_tvalid),
		.key    (key_in),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	vsmd_store #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (slot_q),
		.rdata (mem_rdata)
	);

	// entry layout: valid mark on top, then turns, then key
	assign ent_valid = mem_rdata[ENTRY_W-1];
	assign ent_turns = mem_rdata[KEY_BITS +: TURN_W];
	assign ent_key   = mem_rdata[KEY_BITS-1:0];

	// the finished result may go out once the output register is empty or drains
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		res_done   = 1'b0;
		res_write  = 1'b0;
		res_inc    = 1'b0;
		res_status = ST_MISS;
		res_held   = '0;
		if (!ent_valid) begin
			// empty slot ends the probe: insert or miss
			res_done = 1'b1;
			if (op_q == OP_TEST_SET) begin
				res_write  = 1'b1;
				res_inc    = 1'b1;
				res_status = ST_STORED;
				res_held   = turns_q;
			end
		end else if (ent_key == key_q) begin
			res_done = 1'b1;
			if (op_q == OP_LOOKUP) begin
				res_status = ST_HIT;
				res_held   = ent_turns;
			end else if (turns_q < ent_turns) begin
				res_write  = 1'b1;
				res_status = ST_STORED;
				res_held   = turns_q;
			end else if (turns_q == ent_turns) begin
				res_status = ST_EQUAL;
				res_held   = ent_turns;
			end else begin
				res_status = ST_WORSE;
				res_held   = ent_turns;
			end
		end else if (probe_q == PROBE_LAST) begin
			// window used up without a match or a free slot
			res_done   = 1'b1;
			res_status = (op_q == OP_TEST_SET) ? ST_FULL : ST_MISS;
		end
	end

	// the probe ends here and its result transaction is loaded
	assign res_fire = (state_q == S_CHECK) && out_free && res_done;

	assign occ_next = occ_q + CNT_W'(res_inc);
	assign occ_wide = 32'(occ_next);

	// memory read enable, and the write: clearing sweep or commit of the probe decision
	always_comb begin
		mem_re    = (state_q == S_READ);
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = {1'b1, turns_q, key_q};
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == S_CHECK && out_free && res_write) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			op_q      <= OP_TEST_SET;
			key_q     <= '0;
			turns_q   <= '0;
			slot_q    <= '0;
			clr_q     <= '0;
			probe_q   <= '0;
			occ_q     <= '0;
			m_valid_q <= 1'b0;
			status_q  <= ST_MISS;
			held_q    <= '0;
			count_q   <= '0;
		end else begin
			if (res_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= op_t'(s_axis_tuser[0]);
						key_q   <= key_in[KEY_BITS-1:0];
						turns_q <= s_axis_tdata[71:64];
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						slot_q  <= hash_slot;
						probe_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// wait here with read data held until the output side has room
					if (out_free) begin
						if (res_done) begin
							occ_q    <= occ_next;
							status_q <= res_status;
							held_q   <= res_held;
							count_q  <= occ_wide[COUNT_W-1:0];
							state_q  <= S_IDLE;
						end else begin
							// linear probe with wrap-around
							slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
							probe_q <= probe_q + PRB_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, count_q, held_q};
	assign m_axis_tuser  = status_q;

	// a fresh result only follows a table check
	`VSMD_ASSERT_NOW(a_result_from_check, clk, arst_n, $rose(m_valid_q),
		$past(state_q) == S_CHECK)
	// an accepted input transaction starts the hash
	`VSMD_ASSERT_NEXT(a_accept_to_hash, clk, arst_n, s_axis_tvalid && s_axis_tready,
		state_q == S_HASH)
	// occupancy moves only by one, with a stored result going out
	`VSMD_ASSERT_NOW(a_occ_step, clk, arst_n, occ_q != $past(occ_q),
		occ_q == $past(occ_q) + CNT_W'(1) && m_valid_q && status_q == ST_STORED)
	// the table never counts more entries than slots
	`VSMD_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CNT_W'(CAPACITY))

endmodule
